FILE: rtl/bf16_softmax_row_unit_assert.svh
// assertion macros shared by the softmax row unit
`ifndef BF16_SOFTMAX_ROW_UNIT_ASSERT_SVH
`define BF16_SOFTMAX_ROW_UNIT_ASSERT_SVH

// same-cycle implication
`define BSR_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Types, constants and tables of the bfloat16 softmax row unit.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int MAX_COUNT_DEF = 64;

  localparam logic [15:0] BF_NEG_MAX = 16'hFF7F;
  localparam logic [15:0] BF_NAN     = 16'h7FC0;
  localparam logic [24:0] ONE_Q24    = 25'd16777216;
  localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
  localparam logic [23:0] LN2_Q24    = 24'd11629080;
  localparam logic [21:0] T_CLAMP    = 22'd2097152;
  localparam logic [16:0] RECIP6     = 17'd43691;
  localparam logic [5:0]  DIV_STEPS  = 6'd54;

  localparam logic [24:0] EXP2_FRAC [16] = '{
    25'd16777216, 25'd16065917, 25'd15384775, 25'd14732511,
    25'd14107901, 25'd13509772, 25'd12937002, 25'd12388516,
    25'd11863283, 25'd11360319, 25'd10878679, 25'd10417458,
    25'd9975792,  25'd9552851,  25'd9147842,  25'd8760003
  };

  typedef struct packed {
    logic [15:0] value;
    logic        row_end;
  } bsr_in_t;

  typedef struct packed {
    logic [15:0] prob;
    logic        out_last;
    logic        overflow;
  } bsr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP,
    ST_EXP_WAIT,
    ST_DIV,
    ST_NORM,
    ST_NORM_WAIT
  } bsr_state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_last;
    logic norm;
    logic div_start;
    logic row_clear;
  } bsr_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic out_done;
  } bsr_sts_t;

endpackage

FILE: rtl/bsr_ram.sv
// ----------------------------------------------------------------------------
// bsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsr_ctrl.sv
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer: row load, exponent pass, reciprocal, normalize pass.
// ----------------------------------------------------------------------------
`include "bf16_softmax_row_unit_assert.svh"

module bsr_ctrl import bsr_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             row_end,
  output logic                             busy,
  input  logic [$clog2(MAX_COUNT+1)-1:0]   fill,
  input  bsr_sts_t                         sts,
  output bsr_cmd_t                         cmd,
  output logic [$clog2(MAX_COUNT)-1:0]     rd_idx
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int AW = $clog2(MAX_COUNT);

  bsr_state_t    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          at_last;

  assign at_last = (idx_r == fill - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (start && row_end) begin
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        idx_nxt = idx_r + CW'(1);
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = ST_EXP_WAIT;
        end
      end
      ST_EXP_WAIT: begin
        if (sts.sum_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        idx_nxt = idx_r + CW'(1);
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = ST_NORM_WAIT;
        end
      end
      ST_NORM_WAIT: begin
        if (sts.out_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXP: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = at_last;
      end
      ST_EXP_WAIT: begin
        cmd.div_start = sts.sum_done;
      end
      ST_DIV: begin
        cmd.norm = 1'b0;
      end
      ST_NORM: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = at_last;
        cmd.norm    = 1'b1;
      end
      ST_NORM_WAIT: begin
        cmd.norm      = 1'b1;
        cmd.row_clear = sts.out_done;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign rd_idx = idx_r[AW-1:0];

  `BSR_ASSERT_IMP(a_no_out_idle, clk, rst_n, state_r == ST_IDLE, !sts.out_done, "result while idle")
  `BSR_ASSERT_IMP(a_div_in_state, clk, rst_n, sts.div_done, state_r == ST_DIV, "stray divide done")
  `BSR_ASSERT_NXT(a_row_closes, clk, rst_n, state_r == ST_NORM_WAIT && sts.out_done, state_r == ST_IDLE, "row did not close")
  `BSR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill <= CW'(MAX_COUNT), "fill beyond capacity")

endmodule

FILE: rtl/bsr_dp.sv
// ----------------------------------------------------------------------------
// bsr_dp
// Row store, maximum tracking, exponent pipeline, serial divider, rounding.
// ----------------------------------------------------------------------------
module bsr_dp import bsr_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bsr_in_t                        in_data,
  input  bsr_cmd_t                       cmd,
  input  logic [$clog2(MAX_COUNT)-1:0]   rd_idx,
  output logic [$clog2(MAX_COUNT+1)-1:0] fill,
  output bsr_sts_t                       sts,
  output logic                           out_valid,
  output bsr_out_t                       out_data
);

  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int AW = $clog2(MAX_COUNT);

  function automatic logic is_nan(input logic [15:0] b);
    return (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
  endfunction

  function automatic logic [15:0] order_key(input logic [15:0] b);
    return b[15] ? ~b : (b | 16'h8000);
  endfunction

  function automatic logic signed [30:0] to_q16(input logic [15:0] b);
    logic [7:0]  m;
    logic [7:0]  ee;
    logic [7:0]  sh;
    logic [28:0] mag;
    m  = (b[14:7] != 8'd0) ? {1'b1, b[6:0]} : {1'b0, b[6:0]};
    ee = (b[14:7] != 8'd0) ? b[14:7] : 8'd1;
    if (ee >= 8'd118) begin
      sh  = ee - 8'd118;
      mag = {21'd0, m} << sh[4:0];
    end else begin
      sh  = 8'd118 - ee;
      mag = (sh >= 8'd8) ? 29'd0 : {21'd0, m >> sh[2:0]};
    end
    return b[15] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  endfunction

  function automatic logic [21:0] neg_diff(input logic [15:0] x, input logic [15:0] mx);
    logic signed [31:0] d;
    d = 32'(to_q16(mx)) - 32'(to_q16(x));
    if (x == mx) begin
      return 22'd0;
    end else if (x[14:7] >= 8'd140 || mx[14:7] >= 8'd140) begin
      return T_CLAMP;
    end else if (d < 0) begin
      return 22'd0;
    end else if (d > $signed({10'd0, T_CLAMP})) begin
      return T_CLAMP;
    end
    return d[21:0];
  endfunction

  function automatic logic [5:0] lead_one(input logic [55:0] p);
    logic [5:0] h;
    h = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (p[i]) begin
        h = 6'(i);
      end
    end
    return h;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [55:0] p, input logic [5:0] h);
    logic [5:0]  s;
    logic [55:0] sh;
    logic [7:0]  m8;
    logic        rb;
    logic        sticky;
    logic        up;
    logic [15:0] ex;
    rb = 1'b0;
    sticky = 1'b0;
    if (h < 6'd7) begin
      s  = 6'd0;
      m8 = p[7:0] << (3'd7 - h[2:0]);
    end else begin
      s  = h - 6'd7;
      sh = p >> s;
      m8 = sh[7:0];
      if (s != 6'd0) begin
        rb     = p[s - 6'd1];
        sticky = |(p & ((56'd1 << (s - 6'd1)) - 56'd1));
      end
    end
    up = rb && (sticky || m8[0]);
    ex = {2'd0, 6'(h + 6'd9) + 7'd64, 7'd0};
    if (p == 56'd0) begin
      return 16'd0;
    end
    return ex + {9'd0, m8[6:0]} + {15'd0, up};
  endfunction

  // load side
  logic [15:0]   vin;
  logic          wr_en;
  logic [CW-1:0] fill_r;
  logic [15:0]   max_r;
  logic          nan_r;
  logic          ovf_r;
  logic [15:0]   rdata;

  assign vin   = (in_data.value[14:0] == 15'h7F80) ?
                 {in_data.value[15], 15'h7F7F} : in_data.value;
  assign wr_en = cmd.load && (fill_r < CW'(MAX_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.row_clear) begin
      fill_r <= '0;
      max_r  <= BF_NEG_MAX;
      nan_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (cmd.load) begin
      if (wr_en) begin
        fill_r <= fill_r + CW'(1);
        nan_r  <= nan_r | is_nan(vin);
        if (!is_nan(vin) && order_key(vin) > order_key(max_r)) begin
          max_r <= vin;
        end
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  bsr_ram #(.WIDTH(16), .DEPTH(MAX_COUNT)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_r[AW-1:0]),
    .wdata (vin),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // exponent pipeline
  logic [10:1]  v_r;
  logic [10:1]  l_r;
  logic [21:0]  s2_t_r;
  logic [46:0]  u_full;
  logic [5:0]   s3_n_r, s4_n_r, s5_n_r, s6_n_r, s7_n_r;
  logic [3:0]   s3_i_r, s4_i_r, s5_i_r, s6_i_r, s7_i_r;
  logic [11:0]  s3_r_r;
  logic [35:0]  z_full;
  logic [19:0]  s4_z_r, s5_z_r, s6_z_r;
  logic [39:0]  z2_full;
  logic [15:0]  s5_z2_r, s6_z2_r;
  logic [35:0]  z3_full;
  logic [11:0]  s6_z3_r;
  logic [28:0]  z3d_full;
  logic [24:0]  p_nxt;
  logic [24:0]  s7_p_r;
  logic [49:0]  tp_full;
  logic [24:0]  e_nxt;
  logic [24:0]  s8_e_r;
  logic [30:0]  sum_r;
  logic         sum_done_r;
  logic [55:0]  s9_p_r, s10_p_r;
  logic [5:0]   s10_h_r;
  logic [30:0]  k_r;
  logic [30:0]  rem_r;
  logic [31:0]  rem2;
  logic         ge;
  logic [5:0]   div_cnt_r;
  logic         div_busy_r;
  logic         div_done_r;
  logic         out_valid_r;
  bsr_out_t     out_data_r;

  assign u_full   = 47'(s2_t_r) * 47'(LOG2E_Q24);
  assign z_full   = 36'(s3_r_r) * 36'(LN2_Q24);
  assign z2_full  = 40'(s4_z_r) * 40'(s4_z_r);
  assign z3_full  = 36'(s5_z2_r) * 36'(s5_z_r);
  assign z3d_full = 29'(s6_z3_r) * 29'(RECIP6);
  assign p_nxt    = ONE_Q24 - 25'(s6_z_r) + 25'(s6_z2_r[15:1]) - 25'(z3d_full[28:18]);
  assign tp_full  = 50'(EXP2_FRAC[s7_i_r]) * 50'(s7_p_r);
  assign e_nxt    = s7_n_r[5] ? 25'd0 : 25'(tp_full[49:24] >> s7_n_r[4:0]);

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, sum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      l_r         <= '0;
      sum_r       <= '0;
      sum_done_r  <= 1'b0;
      div_busy_r  <= 1'b0;
      div_cnt_r   <= '0;
      div_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r[1]  <= cmd.rd_en;
      l_r[1]  <= cmd.rd_last;
      v_r[8:2] <= v_r[7:1];
      l_r[8:2] <= l_r[7:1];
      v_r[9]  <= v_r[8] && cmd.norm;
      l_r[9]  <= l_r[8];
      v_r[10] <= v_r[9];
      l_r[10] <= l_r[9];
      if (cmd.row_clear) begin
        sum_r <= '0;
      end else if (v_r[8] && !cmd.norm) begin
        sum_r <= sum_r + 31'(s8_e_r);
      end
      sum_done_r <= v_r[8] && l_r[8] && !cmd.norm;
      div_done_r <= div_busy_r && (div_cnt_r == 6'd1);
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= DIV_STEPS;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) begin
          div_busy_r <= 1'b0;
        end
      end
      out_valid_r <= v_r[10];
    end
  end

  always_ff @(posedge clk) begin
    s2_t_r  <= neg_diff(rdata, max_r);
    s3_n_r  <= u_full[45:40];
    s3_i_r  <= u_full[39:36];
    s3_r_r  <= u_full[35:24];
    s4_z_r  <= z_full[35:16];
    s4_n_r  <= s3_n_r;
    s4_i_r  <= s3_i_r;
    s5_z2_r <= z2_full[39:24];
    s5_z_r  <= s4_z_r;
    s5_n_r  <= s4_n_r;
    s5_i_r  <= s4_i_r;
    s6_z3_r <= z3_full[35:24];
    s6_z2_r <= s5_z2_r;
    s6_z_r  <= s5_z_r;
    s6_n_r  <= s5_n_r;
    s6_i_r  <= s5_i_r;
    s7_p_r  <= p_nxt;
    s7_n_r  <= s6_n_r;
    s7_i_r  <= s6_i_r;
    s8_e_r  <= e_nxt;
    s9_p_r  <= 56'(s8_e_r) * 56'(k_r);
    s10_p_r <= s9_p_r;
    s10_h_r <= lead_one(s9_p_r);
    out_data_r.prob     <= nan_r ? BF_NAN : to_bf16(s10_p_r, s10_h_r);
    out_data_r.out_last <= l_r[10];
    out_data_r.overflow <= ovf_r;
    if (cmd.div_start) begin
      rem_r <= 31'd1;
      k_r   <= '0;
    end else if (div_busy_r) begin
      rem_r <= ge ? 31'(rem2 - {1'b0, sum_r}) : rem2[30:0];
      k_r   <= {k_r[29:0], ge};
    end
  end

  assign fill         = fill_r;
  assign sts.sum_done = sum_done_r;
  assign sts.div_done = div_done_r;
  assign sts.out_done = out_valid_r && out_data_r.out_last;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

FILE: rtl/bf16_softmax_row_unit.sv
// ----------------------------------------------------------------------------
// bf16_softmax_row_unit
// Softmax over one row of bfloat16 elements, results emitted in order.
// ----------------------------------------------------------------------------
// Usage: raise start with in_data for one element; the word is taken when
// busy is low. While the row loads, one word is taken per cycle. The word
// with row_end set closes the row and busy rises until the row's last
// probability has been shown.
// For a row of n stored elements the unit then runs an exponent pass of
// n reads through a nine-stage pipeline, a 54-step serial reciprocal, and
// a normalize pass of n reads through an eleven-stage path. Results come
// one per cycle on out_valid/out_data for exactly one cycle each; the
// receiver cannot stall and must take them.
// Elements beyond MAX_COUNT are dropped and flag overflow on every result.
// Reset (synchronous, active low) empties the row and returns to idle.
// ----------------------------------------------------------------------------
module bf16_softmax_row_unit import bsr_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bsr_in_t  in_data,
  output logic     out_valid,
  output bsr_out_t out_data
);

  bsr_cmd_t                        cmd;
  bsr_sts_t                        sts;
  logic [$clog2(MAX_COUNT+1)-1:0]  fill;
  logic [$clog2(MAX_COUNT)-1:0]    rd_idx;

  bsr_ctrl #(.MAX_COUNT(MAX_COUNT)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .row_end (in_data.row_end),
    .busy    (busy),
    .fill    (fill),
    .sts     (sts),
    .cmd     (cmd),
    .rd_idx  (rd_idx)
  );

  bsr_dp #(.MAX_COUNT(MAX_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .fill      (fill),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bf16_softmax_row_unit. Words are sent on the
// start/busy handshake and a bit-exact softmax predictor queues the expected
// probabilities. A monitor checks each strobed result against that queue.
// ----------------------------------------------------------------------------
module tb import bsr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_DEPTH = 64;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bsr_in_t  in_data = '0;
  logic     out_valid;
  bsr_out_t out_data;

  bf16_softmax_row_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  bit [15:0] row_buf [ROW_DEPTH];
  bit [15:0] row_peak = BF_NEG_MAX;
  int        row_fill = 0;
  bit        row_ovf = 1'b0;
  bsr_out_t  prob_q [$];
  int        err_count = 0;
  int        sent_count = 0;

  function automatic bit is_nan(bit [15:0] b);
    return b[14:7] == 8'hFF && b[6:0] != 0;
  endfunction

  function automatic bit [15:0] order_key(bit [15:0] b);
    return b[15] ? ~b : (b | 16'h8000);
  endfunction

  function automatic longint q16_of(bit [15:0] b);
    longint unsigned m, mag;
    int unsigned ee;
    m   = (b[14:7] != 0) ? (64'h80 | b[6:0]) : b[6:0];
    ee  = (b[14:7] != 0) ? b[14:7] : 1;
    if (ee >= 118) mag = (ee - 118 < 32) ? (m << (ee - 118)) : 0;
    else mag = (118 - ee < 32) ? (m >> (118 - ee)) : 0;
    return b[15] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned gap_of(bit [15:0] x, bit [15:0] mx);
    longint d;
    if (x == mx) return 0;
    if (x[14:7] >= 140 || mx[14:7] >= 140) return T_CLAMP;
    d = q16_of(mx) - q16_of(x);
    if (d < 0) d = 0;
    if (d > longint'(T_CLAMP)) d = T_CLAMP;
    return d;
  endfunction

  function automatic longint unsigned exp_of(longint unsigned t);
    longint unsigned u, f, r, z, z2, z3, p, e, n;
    u  = (t * LOG2E_Q24) >> 24;
    n  = u >> 16;
    f  = u & 16'hFFFF;
    r  = f & 12'hFFF;
    z  = (r * LN2_Q24) >> 16;
    z2 = (z * z) >> 24;
    z3 = (z2 * z) >> 24;
    p  = longint'(ONE_Q24) - z + (z2 >> 1) - z3 / 6;
    e  = (longint'(EXP2_FRAC[(f >> 12) & 15]) * p) >> 24;
    if (n >= 32) return 0;
    return e >> n;
  endfunction

  function automatic bit [15:0] bf16_round(longint unsigned p);
    int unsigned h, s, up;
    longint unsigned m, rem, half;
    h  = 0;
    up = 0;
    if (p == 0) return 16'h0000;
    while (h < 63 && (p >> (h + 1)) != 0) h++;
    if (h < 7) begin
      m = p << (7 - h);
    end else begin
      s = h - 7;
      m = p >> s;
      if (s > 0) begin
        rem  = p & ((64'd1 << s) - 1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && m[0])) up = 1;
      end
    end
    return 16'(((h + 73) << 7) + (m & 7'h7F) + up);
  endfunction

  task automatic predict_word(bit [15:0] v, bit row_end);
    longint unsigned e [ROW_DEPTH];
    longint unsigned sum, k;
    bit any_nan;
    bsr_out_t r;
    sum = 0;
    any_nan = 1'b0;
    if (v[14:0] == 15'h7F80) v = {v[15], 15'h7F7F};
    if (row_fill < ROW_DEPTH) begin
      row_buf[row_fill] = v;
      row_fill++;
      if (!is_nan(v) && order_key(v) > order_key(row_peak)) row_peak = v;
    end else begin
      row_ovf = 1'b1;
    end
    if (!row_end) return;
    for (int i = 0; i < row_fill; i++) if (is_nan(row_buf[i])) any_nan = 1'b1;
    for (int i = 0; i < row_fill; i++) begin
      e[i] = any_nan ? 0 : exp_of(gap_of(row_buf[i], row_peak));
      sum += e[i];
    end
    k = (sum != 0) ? ((64'd1 << 54) / sum) : 0;
    for (int i = 0; i < row_fill; i++) begin
      r.prob     = any_nan ? BF_NAN : bf16_round(e[i] * k);
      r.out_last = (i + 1 == row_fill);
      r.overflow = row_ovf;
      prob_q.push_back(r);
    end
    row_peak = BF_NEG_MAX;
    row_fill = 0;
    row_ovf  = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  always @(posedge clk) begin
    bsr_out_t want;
    if (rst_n && out_valid) begin
      if (prob_q.size() == 0) begin
        report_mismatch("unexpected word", out_data.prob, 16'h0);
      end else begin
        want = prob_q.pop_front();
        if (out_data.prob !== want.prob)
          report_mismatch("prob", out_data.prob, want.prob);
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", out_data.out_last, want.out_last);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(bit [15:0] v, bit row_end, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{value: v, row_end: row_end};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(v, row_end);
    sent_count++;
  endtask

  function automatic bit [15:0] rand_value();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return {1'($urandom), 8'($urandom_range(120, 133)), 7'($urandom)};
  endfunction

  task automatic send_row(bit [15:0] vals [$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1, pick_gap());
  endtask

  task automatic test_directed();
    send_row('{16'h3F80, 16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7F7F,
               16'hFF7F, 16'h0001});
    send_row('{16'h3F80});
    send_row('{16'h4000, 16'h7FC1});
    send_row('{16'h8000, 16'h0000});
    send_row('{16'h3F80, 16'h3F81, 16'h3F80});
    send_row('{16'h4600, 16'h4600, 16'hC600});
    send_row('{16'hFFFF, 16'h3F80, 16'h7FFF});
  endtask

  task automatic test_long_rows();
    bit [15:0] vals [$];
    for (int len = 64; len <= 67; len += 3) begin
      vals.delete();
      repeat (len) vals.push_back(rand_value());
      send_row(vals);
    end
  endtask

  task automatic test_random_rows();
    bit [15:0] vals [$];
    int len;
    while (sent_count < 270) begin
      vals.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      repeat (len) vals.push_back(rand_value());
      if ($urandom_range(0, 29) == 0) vals[$urandom_range(0, len - 1)] = 16'h7F81;
      send_row(vals);
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_long_rows();
    test_random_rows();
    start <= 1'b0;
    waited = 0;
    while (prob_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (err_count == 0 && prob_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bsr_pkg.sv
rtl/bsr_ram.sv
rtl/bsr_ctrl.sv
rtl/bsr_dp.sv
rtl/bf16_softmax_row_unit.sv
sim/tb.sv
